// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types, phase codes and constants for the I2C master transfer engine.
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAIT_HDR, PH_WAIT_DATA, PH_START_D, PH_RS_W, PH_RS_D1, PH_RS_D2,
    PH_SP_A, PH_SP_W, PH_SP_D1, PH_SP_D2, PH_SP_D3, PH_RT_D, PH_WB_D, PH_WB_W,
    PH_WB_H, PH_WA_D1, PH_WA_D2, PH_WA_W, PH_WA_H, PH_RB_D, PH_RB_W, PH_RB_H,
    PH_RB_L, PH_AK_D, PH_AK_W, PH_AK_H
  } phase_t;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_HDR  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ADDR    = 2'd1;
  localparam logic [1:0] ST_WNACK   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] CFG_RETRY   = 2'd0;
  localparam logic [1:0] CFG_STRETCH = 2'd1;
  localparam logic [1:0] CFG_PHASE   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  address;
    logic        is_read;
    logic        ten_bit;
    logic        nack_ok;
    logic        no_start;
    logic        no_read_ack;
    logic [7:0]  write_byte;
    logic        last_of_message;
    logic        last_message;
    logic        scl_sample;
    logic        sda_sample;
  } item_t;

  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        ready_res;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        transfer_done;
    logic [1:0]  status;
    logic [7:0]  messages_done;
  } result_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] stretch_timeout;
    logic [9:0]  phase_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// Valid/ready channel interfaces for items and results.
interface i2cm_in_if;
  logic            valid;
  logic            ready;
  i2cm_pkg::item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2cm_out_if;
  logic              valid;
  logic              ready;
  i2cm_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/i2cm_cfg.sv =====
// Configuration register file.
module i2cm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [1:0]        idx,
  input  logic [15:0]       wdata,
  output i2cm_pkg::cfg_t    cfg
);
  i2cm_pkg::cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit     <= 4'd1;
      cfg_r.stretch_timeout <= 16'd100;
      cfg_r.phase_ticks     <= 10'd1;
    end else if (we) begin
      case (idx)
        i2cm_pkg::CFG_RETRY:   cfg_r.retry_limit     <= wdata[3:0];
        i2cm_pkg::CFG_STRETCH: cfg_r.stretch_timeout <= wdata;
        i2cm_pkg::CFG_PHASE:   cfg_r.phase_ticks     <= wdata[9:0];
        default: ;
      endcase
    end
  end
  assign cfg = cfg_r;
endmodule

// ===== hw/rtl/i2cm_core.sv =====
// Bus phase sequencer: one tick of the transfer engine per accepted item.
module i2cm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  i2cm_pkg::item_t    item,
  input  i2cm_pkg::cfg_t     cfg,
  output i2cm_pkg::result_t  res
);
  i2cm_pkg::phase_t ph_r, ph_nxt;
  logic [9:0]  pt_r, pt_nxt;
  logic [15:0] st_r, st_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  rc_r, rc_nxt;
  logic [1:0]  as_r, as_nxt;
  logic [5:0]  fl_r, fl_nxt;
  logic [9:0]  ad_r, ad_nxt;
  logic [7:0]  mc_r, mc_nxt;
  logic [1:0]  sr_r, sr_nxt;
  logic        it_r, it_nxt;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;

  logic [9:0]  pt_inc, pt_lim;
  logic        dly;
  logic        sw_hi, sw_to;
  logic        rv;
  logic [7:0]  rb;
  logic        dn;
  logic        ign;
  logic [3:0]  lim;
  logic [7:0]  hi;

  function automatic logic [7:0] abyte(input logic [1:0] s, input logic [9:0] a,
                                       input logic [5:0] f);
    logic [7:0] h;
    h = 8'hF0 | ({5'd0, a[9:7]} & 8'h06);
    if (s == 2'd2) abyte = a[7:0];
    else if (s == 2'd3) abyte = h | 8'h01;
    else if (f[1]) abyte = h;
    else abyte = {a[6:0], f[0]};
  endfunction

  assign pt_inc = pt_r + 10'd1;
  assign pt_lim = (cfg.phase_ticks == 10'd0) ? 10'd1 : cfg.phase_ticks;
  assign dly    = pt_inc >= pt_lim;
  assign sw_hi  = item.scl_sample;
  assign sw_to  = !item.scl_sample && (st_r >= cfg.stretch_timeout);
  assign ign    = fl_r[2];
  assign lim    = ign ? 4'd0 : cfg.retry_limit;
  assign hi     = 8'd0;

  always_comb begin
    logic [1:0] rs; // 1 ack, 0 nack, 2 timeout
    logic tmo;
    ph_nxt = ph_r; pt_nxt = pt_r; st_nxt = st_r; bc_nxt = bc_r; sh_nxt = sh_r;
    rc_nxt = rc_r; as_nxt = as_r; fl_nxt = fl_r; ad_nxt = ad_r; mc_nxt = mc_r;
    sr_nxt = sr_r; it_nxt = it_r; scl_nxt = scl_r; sda_nxt = sda_r;
    rv = 1'b0; rb = hi; dn = 1'b0; rs = 2'd0; tmo = 1'b0;

    // Enter helper expanded inline via macros-free repeat
    case (ph_r)
      i2cm_pkg::PH_IDLE, i2cm_pkg::PH_WAIT_HDR: begin
        if (item.operation == i2cm_pkg::OP_HDR) begin
          ad_nxt = item.address;
          fl_nxt = {item.last_of_message, item.last_message, item.no_read_ack,
                    item.nack_ok, item.ten_bit, item.is_read};
          rc_nxt = 4'd0;
          if (ph_r == i2cm_pkg::PH_IDLE) begin
            it_nxt = 1'b1; sr_nxt = i2cm_pkg::ST_OK; mc_nxt = 8'd0;
            as_nxt = item.no_start ? 2'd0 : 2'd1;
            sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_START_D; pt_nxt = '0; st_nxt = '0;
          end else if (item.no_start) begin
            as_nxt = 2'd0; pt_nxt = '0; st_nxt = '0;
            if (item.last_of_message) begin
              if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
              if (item.last_message) begin
                sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
              end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
            end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
          end else begin
            as_nxt = 2'd1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            ph_nxt = i2cm_pkg::PH_RS_W; pt_nxt = '0; st_nxt = '0;
          end
        end
      end
      i2cm_pkg::PH_WAIT_DATA: begin
        if (item.operation == i2cm_pkg::OP_DATA) begin
          fl_nxt[5] = item.last_of_message;
          pt_nxt = '0; st_nxt = '0; bc_nxt = 4'd0;
          if (fl_r[0]) begin
            sda_nxt = 1'b1; sh_nxt = 8'd0; ph_nxt = i2cm_pkg::PH_RB_D;
          end else begin
            sh_nxt = item.write_byte; scl_nxt = 1'b0; sda_nxt = item.write_byte[7];
            ph_nxt = i2cm_pkg::PH_WB_D;
          end
        end
      end
      i2cm_pkg::PH_START_D: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b0; pt_nxt = '0; st_nxt = '0;
          if (as_r == 2'd0) begin
            if (fl_r[5]) begin
              if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
              if (fl_r[4]) begin
                sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
              end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
            end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
          end else begin
            sh_nxt = abyte(as_r, ad_r, fl_r); bc_nxt = 4'd0;
            sda_nxt = sh_nxt[7]; ph_nxt = i2cm_pkg::PH_WB_D;
          end
        end
      end
      i2cm_pkg::PH_RS_W, i2cm_pkg::PH_SP_W: begin
        if (sw_hi || sw_to) begin
          pt_nxt = '0; st_nxt = '0;
          if (ph_r == i2cm_pkg::PH_RS_W)
            ph_nxt = sw_hi ? i2cm_pkg::PH_RS_D1 : i2cm_pkg::PH_RS_D2;
          else
            ph_nxt = sw_hi ? i2cm_pkg::PH_SP_D1 : i2cm_pkg::PH_SP_D2;
        end else st_nxt = st_r + 16'd1;
      end
      i2cm_pkg::PH_RS_D1: begin
        pt_nxt = pt_inc;
        if (dly) begin ph_nxt = i2cm_pkg::PH_RS_D2; pt_nxt = '0; st_nxt = '0; end
      end
      i2cm_pkg::PH_RS_D2, i2cm_pkg::PH_RT_D: begin
        pt_nxt = pt_inc;
        if (dly) begin
          sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_START_D; pt_nxt = '0; st_nxt = '0;
        end
      end
      i2cm_pkg::PH_SP_A: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b1; ph_nxt = i2cm_pkg::PH_SP_W; pt_nxt = '0; st_nxt = '0;
        end
      end
      i2cm_pkg::PH_SP_D1: begin
        pt_nxt = pt_inc;
        if (dly) begin ph_nxt = i2cm_pkg::PH_SP_D2; pt_nxt = '0; st_nxt = '0; end
      end
      i2cm_pkg::PH_SP_D2: begin
        pt_nxt = pt_inc;
        if (dly) begin
          sda_nxt = 1'b1; ph_nxt = i2cm_pkg::PH_SP_D3; pt_nxt = '0; st_nxt = '0;
        end
      end
      i2cm_pkg::PH_SP_D3: begin
        pt_nxt = pt_inc;
        if (dly) begin
          pt_nxt = '0; st_nxt = '0;
          if (sr_r == i2cm_pkg::ST_OK && as_r != 2'd0) ph_nxt = i2cm_pkg::PH_RT_D;
          else begin
            dn = 1'b1; it_nxt = 1'b0; scl_nxt = 1'b1; sda_nxt = 1'b1;
            ph_nxt = i2cm_pkg::PH_IDLE;
          end
        end
      end
      i2cm_pkg::PH_WB_D, i2cm_pkg::PH_WA_D2, i2cm_pkg::PH_RB_D, i2cm_pkg::PH_AK_D: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b1; pt_nxt = '0; st_nxt = '0;
          case (ph_r)
            i2cm_pkg::PH_WB_D:  ph_nxt = i2cm_pkg::PH_WB_W;
            i2cm_pkg::PH_WA_D2: ph_nxt = i2cm_pkg::PH_WA_W;
            i2cm_pkg::PH_RB_D:  ph_nxt = i2cm_pkg::PH_RB_W;
            default:            ph_nxt = i2cm_pkg::PH_AK_W;
          endcase
        end
      end
      i2cm_pkg::PH_WB_W, i2cm_pkg::PH_WA_W: begin
        if (sw_hi) begin
          pt_nxt = '0; st_nxt = '0;
          ph_nxt = (ph_r == i2cm_pkg::PH_WB_W) ? i2cm_pkg::PH_WB_H : i2cm_pkg::PH_WA_H;
        end else if (sw_to) begin
          tmo = 1'b1; rs = 2'd2;
        end else st_nxt = st_r + 16'd1;
      end
      i2cm_pkg::PH_WB_H: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b0; pt_nxt = '0; st_nxt = '0;
          if (bc_r < 4'd7) begin
            bc_nxt = bc_r + 4'd1; sh_nxt = {sh_r[6:0], 1'b0}; sda_nxt = sh_r[6];
            ph_nxt = i2cm_pkg::PH_WB_D;
          end else ph_nxt = i2cm_pkg::PH_WA_D1;
        end
      end
      i2cm_pkg::PH_WA_D1: begin
        pt_nxt = pt_inc;
        if (dly) begin
          sda_nxt = 1'b1; ph_nxt = i2cm_pkg::PH_WA_D2; pt_nxt = '0; st_nxt = '0;
        end
      end
      i2cm_pkg::PH_WA_H: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b0; tmo = 1'b1; rs = item.sda_sample ? 2'd0 : 2'd1;
        end
      end
      i2cm_pkg::PH_RB_W, i2cm_pkg::PH_AK_W: begin
        if (sw_hi) begin
          pt_nxt = '0; st_nxt = '0;
          ph_nxt = (ph_r == i2cm_pkg::PH_RB_W) ? i2cm_pkg::PH_RB_H : i2cm_pkg::PH_AK_H;
        end else if (sw_to) begin
          sr_nxt = (ph_r == i2cm_pkg::PH_RB_W) ? i2cm_pkg::ST_ADDR : i2cm_pkg::ST_TIMEOUT;
          sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A; pt_nxt = '0; st_nxt = '0;
        end else st_nxt = st_r + 16'd1;
      end
      i2cm_pkg::PH_RB_H: begin
        pt_nxt = pt_inc;
        if (dly) begin
          sh_nxt = {sh_r[6:0], item.sda_sample}; bc_nxt = bc_r + 4'd1;
          scl_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_RB_L; pt_nxt = '0; st_nxt = '0;
        end
      end
      i2cm_pkg::PH_RB_L: begin
        pt_nxt = pt_inc;
        if (dly) begin
          pt_nxt = '0; st_nxt = '0;
          if (bc_r >= 4'd8) begin
            rv = 1'b1; rb = sh_r;
            if (!fl_r[3]) begin
              if (!fl_r[5]) sda_nxt = 1'b0;
              ph_nxt = i2cm_pkg::PH_AK_D;
            end else if (fl_r[5]) begin
              if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
              if (fl_r[4]) begin
                sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
              end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
            end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
          end else begin
            scl_nxt = 1'b1; ph_nxt = i2cm_pkg::PH_RB_W;
          end
        end
      end
      i2cm_pkg::PH_AK_H: begin
        pt_nxt = pt_inc;
        if (dly) begin
          scl_nxt = 1'b0; pt_nxt = '0; st_nxt = '0;
          if (fl_r[5]) begin
            if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
            if (fl_r[4]) begin
              sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
            end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
          end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
        end
      end
      default: ;
    endcase

    // Byte outcome after a write byte's ACK slot or a clock-stretch timeout during that byte.
    if (tmo) begin
      pt_nxt = '0; st_nxt = '0;
      if (as_r == 2'd1 || as_r == 2'd3) begin
        if (rs != 2'd1 && rc_r < lim) begin
          rc_nxt = rc_r + 4'd1; sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
        end else if (rs != 2'd1 && !ign) begin
          sr_nxt = i2cm_pkg::ST_ADDR; sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
        end else if (as_r == 2'd1 && fl_r[1]) begin
          as_nxt = 2'd2; sh_nxt = ad_r[7:0]; bc_nxt = 4'd0; scl_nxt = 1'b0;
          sda_nxt = ad_r[7]; ph_nxt = i2cm_pkg::PH_WB_D;
        end else begin
          as_nxt = 2'd0;
          if (fl_r[5]) begin
            if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
            if (fl_r[4]) begin
              sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
            end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
          end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
        end
      end else if (as_r == 2'd2) begin
        if (rs != 2'd1 && !ign) begin
          sr_nxt = i2cm_pkg::ST_ADDR; sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
        end else if (fl_r[0]) begin
          as_nxt = 2'd3; rc_nxt = 4'd0; sda_nxt = 1'b1; scl_nxt = 1'b1;
          ph_nxt = i2cm_pkg::PH_RS_W;
        end else begin
          as_nxt = 2'd0;
          if (fl_r[5]) begin
            if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
            if (fl_r[4]) begin
              sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
            end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
          end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
        end
      end else begin
        if (rs == 2'd1 || (rs == 2'd0 && ign)) begin
          if (fl_r[5]) begin
            if (mc_r != 8'hFF) mc_nxt = mc_r + 8'd1;
            if (fl_r[4]) begin
              sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
            end else ph_nxt = i2cm_pkg::PH_WAIT_HDR;
          end else ph_nxt = i2cm_pkg::PH_WAIT_DATA;
        end else begin
          sr_nxt = (rs == 2'd0) ? i2cm_pkg::ST_WNACK : i2cm_pkg::ST_TIMEOUT;
          sda_nxt = 1'b0; ph_nxt = i2cm_pkg::PH_SP_A;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= i2cm_pkg::PH_IDLE; pt_r <= '0; st_r <= '0; bc_r <= '0; sh_r <= '0;
      rc_r <= '0; as_r <= '0; fl_r <= '0; ad_r <= '0; mc_r <= '0; sr_r <= '0;
      it_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1;
      // Both lines released, everything else clear.
      res <= {2'b11, 21'd0};
    end else if (step) begin
      ph_r <= ph_nxt; pt_r <= pt_nxt; st_r <= st_nxt; bc_r <= bc_nxt; sh_r <= sh_nxt;
      rc_r <= rc_nxt; as_r <= as_nxt; fl_r <= fl_nxt; ad_r <= ad_nxt; mc_r <= mc_nxt;
      sr_r <= sr_nxt; it_r <= it_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
      res.scl_release   <= scl_nxt;
      res.sda_release   <= sda_nxt;
      res.ready_res     <= (ph_nxt == i2cm_pkg::PH_IDLE) ||
                           (ph_nxt == i2cm_pkg::PH_WAIT_HDR) ||
                           (ph_nxt == i2cm_pkg::PH_WAIT_DATA);
      res.read_valid    <= rv;
      res.read_byte     <= rb;
      res.transfer_done <= dn;
      res.status        <= sr_nxt;
      res.messages_done <= mc_nxt;
    end
  end
endmodule

// ===== hw/rtl/i2c_master_transfer_engine_unit.sv =====
// Top level of the I2C master transfer engine.
// Each transaction on the input channel is one bus tick: it carries the sampled SCL and SDA
// levels and, optionally, a message header or a data byte request. The engine computes the
// whole tick combinationally into a result register and returns exactly one result
// transaction per tick, so one tick per clock is sustained when the result side keeps up;
// the output register stalls the input only while an unread result is held and not being
// taken in the same cycle. The user must write configuration (retry limit, stretch timeout,
// phase ticks) via the cfg port only while the engine is idle; the block does not check it.
module i2c_master_transfer_engine_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cm_in_if.sink              in_ch,
  i2cm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  i2cm_pkg::cfg_t cfg;
  logic           ov_r;
  logic           step;

  i2cm_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .we(cfg_we), .idx(cfg_index), .wdata(cfg_wdata), .cfg(cfg)
  );

  // Accept a tick whenever the result slot is empty or drains this cycle.
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  i2cm_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_ch.payload), .cfg(cfg),
    .res(out_ch.payload)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_ch.valid = ov_r;

  // Hold a pending result until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("result dropped while stalled");
  // A read byte and a done pulse never come together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.payload.read_valid && out_ch.payload.transfer_done))
    else $error("read and done at once");
  // Finished transfer leaves both lines released.
  a_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.transfer_done |->
      out_ch.payload.scl_release && out_ch.payload.sda_release)
    else $error("lines held after stop");
endmodule

// ===== tb/sv/tb_i2c_master_transfer_engine_unit.sv =====
// Self-checking testbench for the I2C master transfer engine.
`timescale 1ns / 100ps

module tb_i2c_master_transfer_engine_unit;

  // Flag bit positions inside the engine's per-message flags.
  localparam int F_RD = 0, F_TEN = 1, F_IGN = 2, F_NRA = 3, F_LAST = 4, F_END = 5;
  localparam int STALL_LIMIT = 5000;
  // Operation code the engine does not define; it must be ignored.
  localparam logic [1:0] OP_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_transfer_engine_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Generate the 4 ns clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Engine mirror: configuration and state, advanced once per accepted tick.
  logic [3:0]  m_retry_lim;
  logic [15:0] m_stretch_lim;
  logic [9:0]  m_unit;
  i2cm_pkg::phase_t m_ph;
  logic [9:0]  m_ptmr;
  logic [15:0] m_stmr;
  logic [3:0]  m_bits;
  logic [7:0]  m_shift;
  logic [3:0]  m_retries;
  logic [1:0]  m_stage;
  logic [5:0]  m_flags;
  logic [9:0]  m_addr;
  logic [7:0]  m_msgs;
  logic [1:0]  m_status;
  logic        m_busy;
  logic        m_scl, m_sda;

  i2cm_pkg::result_t tick_results_q[$];
  int errors;
  bit calm;      // no idling on either side
  bit draining;  // steer traffic toward the end of the transfer
  int stretch_left;

  function automatic void go(i2cm_pkg::phase_t p);
    m_ph = p;
    m_ptmr = '0;
    m_stmr = '0;
  endfunction

  function automatic bit unit_over();
    logic [9:0] pt;
    pt = (m_unit == 10'd0) ? 10'd1 : m_unit;
    m_ptmr = m_ptmr + 10'd1;
    return m_ptmr >= pt;
  endfunction

  // 1 when SCL is high, -1 on stretch timeout, 0 to keep waiting.
  function automatic int scl_check(logic s);
    if (s) return 1;
    if (m_stmr >= m_stretch_lim) return -1;
    m_stmr = m_stmr + 16'd1;
    return 0;
  endfunction

  function automatic void begin_stop();
    m_sda = 1'b0;
    go(i2cm_pkg::PH_SP_A);
  endfunction

  function automatic void fail_with(logic [1:0] code);
    m_status = code;
    begin_stop();
  endfunction

  function automatic logic [7:0] addr_byte(logic [1:0] stage);
    logic [7:0] hi;
    hi = 8'hF0 | {5'b0, m_addr[9:8], 1'b0};
    if (stage == 2'd2) return m_addr[7:0];
    if (stage == 2'd3) return hi | 8'h01;
    if (m_flags[F_TEN]) return hi;
    return {m_addr[6:0], m_flags[F_RD]};
  endfunction

  function automatic void send_byte(logic [7:0] b);
    m_shift = b;
    m_bits = '0;
    m_scl = 1'b0;
    m_sda = b[7];
    go(i2cm_pkg::PH_WB_D);
  endfunction

  function automatic void msg_complete();
    if (m_msgs < 8'hFF) m_msgs = m_msgs + 8'd1;
    if (m_flags[F_LAST]) begin_stop();
    else go(i2cm_pkg::PH_WAIT_HDR);
  endfunction

  function automatic void byte_done();
    if (m_flags[F_END]) msg_complete();
    else go(i2cm_pkg::PH_WAIT_DATA);
  endfunction

  function automatic void enter_body();
    m_stage = 2'd0;
    byte_done();
  endfunction

  function automatic void begin_restart();
    m_sda = 1'b1;
    m_scl = 1'b1;
    go(i2cm_pkg::PH_RS_W);
  endfunction

  function automatic void byte_outcome(int res);
    bit ign;
    logic [3:0] lim;
    ign = m_flags[F_IGN];
    lim = ign ? 4'd0 : m_retry_lim;
    if (m_stage == 2'd1 || m_stage == 2'd3) begin
      if (res != 1 && m_retries < lim) begin
        m_retries = m_retries + 4'd1;
        begin_stop();
      end else if (res != 1 && !ign) begin
        fail_with(i2cm_pkg::ST_ADDR);
      end else if (m_stage == 2'd1 && m_flags[F_TEN]) begin
        m_stage = 2'd2;
        send_byte(addr_byte(2'd2));
      end else begin
        enter_body();
      end
    end else if (m_stage == 2'd2) begin
      if (res != 1 && !ign) fail_with(i2cm_pkg::ST_ADDR);
      else if (m_flags[F_RD]) begin
        m_stage = 2'd3;
        m_retries = '0;
        begin_restart();
      end else enter_body();
    end else begin
      if (res == 1 || (res == 0 && ign)) byte_done();
      else fail_with(res == 0 ? i2cm_pkg::ST_WNACK : i2cm_pkg::ST_TIMEOUT);
    end
  endfunction

  function automatic void take_header(i2cm_pkg::item_t it, bit first);
    m_addr = it.address;
    m_flags = {it.last_of_message, it.last_message, it.no_read_ack,
               it.nack_ok, it.ten_bit, it.is_read};
    m_retries = '0;
    if (first) begin
      m_busy = 1'b1;
      m_status = i2cm_pkg::ST_OK;
      m_msgs = '0;
      m_stage = it.no_start ? 2'd0 : 2'd1;
      m_sda = 1'b0;
      go(i2cm_pkg::PH_START_D);
    end else if (it.no_start) begin
      enter_body();
    end else begin
      m_stage = 2'd1;
      begin_restart();
    end
  endfunction

  function automatic void engine_reset();
    m_retry_lim = 4'd1; m_stretch_lim = 16'd100; m_unit = 10'd1;
    m_ph = i2cm_pkg::PH_IDLE; m_ptmr = '0; m_stmr = '0; m_bits = '0; m_shift = '0;
    m_retries = '0; m_stage = '0; m_flags = '0; m_addr = '0; m_msgs = '0;
    m_status = i2cm_pkg::ST_OK; m_busy = 1'b0; m_scl = 1'b1; m_sda = 1'b1;
  endfunction

  // Advance the mirror by one tick and return the result the engine should give.
  function automatic i2cm_pkg::result_t step_engine(i2cm_pkg::item_t it);
    int r;
    i2cm_pkg::result_t res;
    res = '0;
    case (m_ph)
      i2cm_pkg::PH_IDLE: if (it.operation == i2cm_pkg::OP_HDR) take_header(it, 1'b1);
      i2cm_pkg::PH_WAIT_HDR: if (it.operation == i2cm_pkg::OP_HDR) take_header(it, 1'b0);
      i2cm_pkg::PH_WAIT_DATA: if (it.operation == i2cm_pkg::OP_DATA) begin
        m_flags[F_END] = it.last_of_message;
        if (m_flags[F_RD]) begin
          m_sda = 1'b1; m_bits = '0; m_shift = '0;
          go(i2cm_pkg::PH_RB_D);
        end else send_byte(it.write_byte);
      end
      i2cm_pkg::PH_START_D: if (unit_over()) begin
        m_scl = 1'b0;
        if (m_stage == 2'd0) enter_body();
        else send_byte(addr_byte(m_stage));
      end
      i2cm_pkg::PH_RS_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_RS_D1); else if (r < 0) go(i2cm_pkg::PH_RS_D2);
      end
      i2cm_pkg::PH_RS_D1: if (unit_over()) go(i2cm_pkg::PH_RS_D2);
      i2cm_pkg::PH_RS_D2: if (unit_over()) begin m_sda = 1'b0; go(i2cm_pkg::PH_START_D); end
      i2cm_pkg::PH_SP_A: if (unit_over()) begin m_scl = 1'b1; go(i2cm_pkg::PH_SP_W); end
      i2cm_pkg::PH_SP_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_SP_D1); else if (r < 0) go(i2cm_pkg::PH_SP_D2);
      end
      i2cm_pkg::PH_SP_D1: if (unit_over()) go(i2cm_pkg::PH_SP_D2);
      i2cm_pkg::PH_SP_D2: if (unit_over()) begin m_sda = 1'b1; go(i2cm_pkg::PH_SP_D3); end
      i2cm_pkg::PH_SP_D3: if (unit_over()) begin
        if (m_status == i2cm_pkg::ST_OK && m_stage != 2'd0) go(i2cm_pkg::PH_RT_D);
        else begin
          res.transfer_done = 1'b1;
          m_busy = 1'b0; m_scl = 1'b1; m_sda = 1'b1;
          go(i2cm_pkg::PH_IDLE);
        end
      end
      i2cm_pkg::PH_RT_D: if (unit_over()) begin m_sda = 1'b0; go(i2cm_pkg::PH_START_D); end
      i2cm_pkg::PH_WB_D: if (unit_over()) begin m_scl = 1'b1; go(i2cm_pkg::PH_WB_W); end
      i2cm_pkg::PH_WB_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_WB_H); else if (r < 0) byte_outcome(-1);
      end
      i2cm_pkg::PH_WB_H: if (unit_over()) begin
        m_scl = 1'b0;
        if (m_bits < 4'd7) begin
          m_bits = m_bits + 4'd1;
          m_shift = {m_shift[6:0], 1'b0};
          m_sda = m_shift[7];
          go(i2cm_pkg::PH_WB_D);
        end else go(i2cm_pkg::PH_WA_D1);
      end
      i2cm_pkg::PH_WA_D1: if (unit_over()) begin m_sda = 1'b1; go(i2cm_pkg::PH_WA_D2); end
      i2cm_pkg::PH_WA_D2: if (unit_over()) begin m_scl = 1'b1; go(i2cm_pkg::PH_WA_W); end
      i2cm_pkg::PH_WA_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_WA_H); else if (r < 0) byte_outcome(-1);
      end
      i2cm_pkg::PH_WA_H: if (unit_over()) begin
        m_scl = 1'b0;
        byte_outcome(it.sda_sample ? 0 : 1);
      end
      i2cm_pkg::PH_RB_D: if (unit_over()) begin m_scl = 1'b1; go(i2cm_pkg::PH_RB_W); end
      i2cm_pkg::PH_RB_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_RB_H); else if (r < 0) fail_with(i2cm_pkg::ST_ADDR);
      end
      i2cm_pkg::PH_RB_H: if (unit_over()) begin
        m_shift = {m_shift[6:0], it.sda_sample};
        m_bits = m_bits + 4'd1;
        m_scl = 1'b0;
        go(i2cm_pkg::PH_RB_L);
      end
      i2cm_pkg::PH_RB_L: if (unit_over()) begin
        if (m_bits >= 4'd8) begin
          res.read_valid = 1'b1;
          res.read_byte = m_shift;
          if (!m_flags[F_NRA]) begin
            if (!m_flags[F_END]) m_sda = 1'b0;
            go(i2cm_pkg::PH_AK_D);
          end else byte_done();
        end else begin
          m_scl = 1'b1;
          go(i2cm_pkg::PH_RB_W);
        end
      end
      i2cm_pkg::PH_AK_D: if (unit_over()) begin m_scl = 1'b1; go(i2cm_pkg::PH_AK_W); end
      i2cm_pkg::PH_AK_W: begin
        r = scl_check(it.scl_sample);
        if (r > 0) go(i2cm_pkg::PH_AK_H); else if (r < 0) fail_with(i2cm_pkg::ST_TIMEOUT);
      end
      i2cm_pkg::PH_AK_H: if (unit_over()) begin m_scl = 1'b0; byte_done(); end
      default: ;
    endcase
    res.scl_release = m_scl;
    res.sda_release = m_sda;
    res.ready_res = (m_ph == i2cm_pkg::PH_IDLE || m_ph == i2cm_pkg::PH_WAIT_HDR ||
                     m_ph == i2cm_pkg::PH_WAIT_DATA);
    res.status = m_status;
    res.messages_done = m_msgs;
    return res;
  endfunction

  // Build a tick that follows the bus: SCL echoes our own release unless the target
  // stretches it, SDA is pulled low by the target most of the time.
  function automatic i2cm_pkg::item_t bus_tick();
    i2cm_pkg::item_t it;
    int pick;
    it = i2cm_pkg::item_t'($bits(i2cm_pkg::item_t)'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.operation = draining ? ($urandom_range(0, 1) ? i2cm_pkg::OP_TICK : OP_NONE)
                              : 2'($urandom_range(0, 3));
    end else if (m_ph == i2cm_pkg::PH_IDLE) begin
      it.operation = (!draining && pick < 35) ? i2cm_pkg::OP_HDR : i2cm_pkg::OP_TICK;
    end else if (m_ph == i2cm_pkg::PH_WAIT_HDR) begin
      it.operation = (pick < 40) ? i2cm_pkg::OP_HDR : i2cm_pkg::OP_TICK;
    end else if (m_ph == i2cm_pkg::PH_WAIT_DATA) begin
      it.operation = (pick < 60) ? i2cm_pkg::OP_DATA : i2cm_pkg::OP_TICK;
    end else begin
      it.operation = i2cm_pkg::OP_TICK;
    end
    if (draining) begin
      it.last_message = 1'b1;
      it.last_of_message = 1'b1;
    end
    if (stretch_left > 0) stretch_left--;
    else if ($urandom_range(0, 99) < 3)
      stretch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
    it.scl_sample = m_scl & (stretch_left == 0);
    it.sda_sample = m_sda & ($urandom_range(0, 9) < 3);
    return it;
  endfunction

  task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch on %s at %0t: got %0h, want %0h", field, $realtime, got, want);
    errors++;
  endtask

  // Offer one tick transaction, hold it until taken, then record its expected result.
  // Call at a falling edge; returns at a falling edge.
  task automatic send_tick(input i2cm_pkg::item_t it, input bit typed,
                           input i2cm_pkg::result_t want);
    i2cm_pkg::result_t r;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    r = step_engine(it);
    tick_results_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Run ticks until the mirror is back at idle, then let the results drain.
  task automatic settle();
    i2cm_pkg::result_t blank;
    blank = '0;
    draining = 1'b1;
    while (m_ph != i2cm_pkg::PH_IDLE) send_tick(bus_tick(), 1'b0, blank);
    draining = 1'b0;
    in_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      i2cm_pkg::CFG_RETRY:   m_retry_lim = val[3:0];
      i2cm_pkg::CFG_STRETCH: m_stretch_lim = val;
      i2cm_pkg::CFG_PHASE:   m_unit = val[9:0];
      default: ;
    endcase
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    i2cm_pkg::result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (tick_results_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        want = tick_results_q.pop_front();
        if (got.scl_release !== want.scl_release)
          report("scl_release", 8'(got.scl_release), 8'(want.scl_release));
        if (got.sda_release !== want.sda_release)
          report("sda_release", 8'(got.sda_release), 8'(want.sda_release));
        if (got.ready_res !== want.ready_res)
          report("ready_res", 8'(got.ready_res), 8'(want.ready_res));
        if (got.read_valid !== want.read_valid)
          report("read_valid", 8'(got.read_valid), 8'(want.read_valid));
        if (got.read_byte !== want.read_byte) report("read_byte", got.read_byte, want.read_byte);
        if (got.transfer_done !== want.transfer_done)
          report("transfer_done", 8'(got.transfer_done), 8'(want.transfer_done));
        if (got.status !== want.status) report("status", 8'(got.status), 8'(want.status));
        if (got.messages_done !== want.messages_done)
          report("messages_done", got.messages_done, want.messages_done);
      end
    end
  end

  // Stall the result side in random bursts, except in the calm final phase.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) out_ch.ready <= 1'b1;
      else if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  typedef struct {
    i2cm_pkg::item_t   it;
    bit                typed;
    i2cm_pkg::result_t want;
  } row_t;

  row_t rows[22];
  i2cm_pkg::result_t idle_res, start_res, none;

  initial begin
    i2cm_pkg::item_t t;
    errors = 0;
    calm = 1'b0;
    draining = 1'b0;
    stretch_left = 0;
    engine_reset();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    idle_res = '0;
    idle_res.scl_release = 1'b1;
    idle_res.sda_release = 1'b1;
    idle_res.ready_res = 1'b1;
    start_res = '0;
    start_res.scl_release = 1'b1;
    none = '0;

    // Directed table: idle ticks, ignored operations, then a 10-bit read header at the
    // top address and the start of its address phase with the target ACKing.
    t = '0;
    t.scl_sample = 1'b1;
    t.sda_sample = 1'b1;
    rows[0] = '{t, 1'b1, idle_res};
    t = '1;
    t.operation = OP_NONE;
    rows[1] = '{t, 1'b1, idle_res};
    t.operation = i2cm_pkg::OP_DATA;
    rows[2] = '{t, 1'b1, idle_res};
    t = '0;
    t.operation = i2cm_pkg::OP_HDR;
    t.address = 10'h3FF;
    t.is_read = 1'b1;
    t.ten_bit = 1'b1;
    t.last_message = 1'b1;
    t.scl_sample = 1'b1;
    t.sda_sample = 1'b1;
    rows[3] = '{t, 1'b1, start_res};
    for (int i = 4; i < 22; i++) begin
      t = '0;
      t.scl_sample = 1'b1;
      t.operation = (i == 10) ? i2cm_pkg::OP_HDR :
                    ((i == 12) ? i2cm_pkg::OP_DATA : i2cm_pkg::OP_TICK);
      rows[i] = '{t, 1'b0, none};
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      t = rows[i].it;
      // Echo the bus for the undirected rows so SCL follows our own release.
      if (!rows[i].typed) t.scl_sample = m_scl;
      send_tick(t, rows[i].typed, rows[i].want);
    end

    // Phases of random traffic, each with its own register setting.
    for (int p = 0; p < 6; p++) begin
      int n;
      case (p)
        1: begin write_reg(i2cm_pkg::CFG_RETRY, 16'd0); write_reg(i2cm_pkg::CFG_STRETCH, 16'd1);
                 write_reg(i2cm_pkg::CFG_PHASE, 16'd1); end
        2: begin write_reg(i2cm_pkg::CFG_RETRY, 16'd15);
                 write_reg(i2cm_pkg::CFG_STRETCH, 16'hFFFF);
                 write_reg(i2cm_pkg::CFG_PHASE, 16'd2); end
        3: begin write_reg(i2cm_pkg::CFG_RETRY, 16'd3); write_reg(i2cm_pkg::CFG_STRETCH, 16'd5);
                 write_reg(i2cm_pkg::CFG_PHASE, 16'd4); end
        4: begin write_reg(i2cm_pkg::CFG_RETRY, 16'd2); write_reg(i2cm_pkg::CFG_STRETCH, 16'd20);
                 write_reg(i2cm_pkg::CFG_PHASE, 16'd3); end
        5: begin write_reg(i2cm_pkg::CFG_RETRY, 16'd1); write_reg(i2cm_pkg::CFG_STRETCH, 16'd3);
                 write_reg(i2cm_pkg::CFG_PHASE, 16'd0); calm = 1'b1; end
        default: ;
      endcase
      cfg_we <= 1'b0;
      n = (p == 3) ? 40 : 100;
      repeat (n) send_tick(bus_tick(), 1'b0, none);
      settle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && tick_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
